/* rtl/sprite_frame_piece_expander_defines.svh */
// Assertion macros used by the checker file of the sprite frame expander.
`ifndef SPRITE_FRAME_PIECE_EXPANDER_DEFINES_SVH
`define SPRITE_FRAME_PIECE_EXPANDER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SFPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SFPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sfpe_pkg.sv */
package sfpe_pkg;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_MANY = 2'd1;
  localparam logic [1:0] ST_NO_SLOTS = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic CFG_SIZE_MODE = 1'b0;
  localparam logic CFG_BASE_TILE = 1'b1;

  localparam logic [15:0] X_BIAS     = 16'h0080;
  localparam logic [7:0]  Y_BIAS     = 8'h70;
  localparam logic [8:0]  LARGE_STEP = 9'd2;
  localparam logic [8:0]  ROW_SKIP   = 9'h010;

  // Each row holds small width, small height, large width, large height.
  localparam logic [6:0] SIZE_TBL [8][4] = '{
    '{7'd8,  7'd8,  7'd16, 7'd16},
    '{7'd8,  7'd8,  7'd32, 7'd32},
    '{7'd8,  7'd8,  7'd64, 7'd64},
    '{7'd16, 7'd16, 7'd32, 7'd32},
    '{7'd16, 7'd16, 7'd64, 7'd64},
    '{7'd32, 7'd32, 7'd64, 7'd64},
    '{7'd16, 7'd32, 7'd32, 7'd64},
    '{7'd16, 7'd32, 7'd32, 7'd32}
  };

  typedef struct packed {
    logic               kind;
    logic [7:0]         data_byte;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic [7:0]         first_slot;
  } in_t;

  typedef struct packed {
    logic [6:0]         sprite_slot;
    logic signed [15:0] pos_x;
    logic [7:0]         pos_y;
    logic [8:0]         tile_idx;
    logic               is_large;
    logic [6:0]         sprite_width;
    logic [6:0]         sprite_height;
    logic               last_piece;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic push;
    out_t res;
  } res_push_t;

endpackage

/* rtl/sfpe_frame.sv */
module sfpe_frame #(
  parameter int MAX_PIECES   = 64,
  parameter int SPRITE_SLOTS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  sfpe_pkg::in_t         item_i,
  input  logic [2:0]            size_mode_i,
  input  logic [8:0]            base_tile_i,
  output sfpe_pkg::res_push_t   push_o
);

  localparam logic [3:0] PH_HDR_FIRST = 4'd0;
  localparam logic [3:0] PH_HDR_LAST  = 4'd7;
  localparam logic [3:0] PH_X         = 4'd8;
  localparam logic [3:0] PH_Y         = 4'd9;
  localparam logic [3:0] PH_HDR_CNT   = 4'd5;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  hdr_q [5];
  logic [7:0]  hdr_d [5];
  logic [8:0]  gtc_q, gtc_d;
  logic [9:0]  pi_q, pi_d;
  logic [7:0]  pend_q, pend_d;
  logic [15:0] bx_q, bx_d;
  logic [15:0] by_q, by_d;
  logic [7:0]  fs_q, fs_d;
  logic        abort_q, abort_d;

  logic [9:0]  total;
  logic [9:0]  lim_small;
  logic [9:0]  free_slots;
  logic        in_large;
  logic        in_small;
  logic [8:0]  gtc_cur;
  logic [8:0]  step_l;
  logic [9:0]  pi_inc;
  logic [1:0]  st;

  assign total      = {2'b00, hdr_q[0]} + {2'b00, hdr_q[1]} + {2'b00, hdr_q[3]};
  assign lim_small  = {2'b00, hdr_q[0]} + {2'b00, hdr_q[1]};
  assign free_slots = 10'(SPRITE_SLOTS) - {2'b00, fs_q};
  assign in_large   = pi_q < {2'b00, hdr_q[0]};
  assign in_small   = pi_q < lim_small;
  assign pi_inc     = pi_q + 10'd1;

  always_comb begin
    gtc_cur = gtc_q;
    if (!in_large && in_small && (pi_q == {2'b00, hdr_q[0]})) begin
      gtc_cur = {1'b0, hdr_q[2]};
    end else if (!in_small && (pi_q == lim_small)) begin
      gtc_cur = {1'b0, hdr_q[4]};
    end
    step_l = gtc_cur + sfpe_pkg::LARGE_STEP;
    if (step_l[4]) begin
      step_l = step_l + sfpe_pkg::ROW_SKIP;
    end
  end

  always_comb begin
    if (total > 10'(MAX_PIECES)) begin
      st = sfpe_pkg::ST_TOO_MANY;
    end else if ((fs_q > 8'(SPRITE_SLOTS)) || (total > free_slots)) begin
      st = sfpe_pkg::ST_NO_SLOTS;
    end else if (total == 10'd0) begin
      st = sfpe_pkg::ST_EMPTY;
    end else begin
      st = sfpe_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    gtc_d   = gtc_q;
    pi_d    = pi_q;
    pend_d  = pend_q;
    bx_d    = bx_q;
    by_d    = by_q;
    fs_d    = fs_q;
    abort_d = abort_q;
    push_o  = '0;
    if (fire_i) begin
      if (item_i.kind == sfpe_pkg::KIND_START) begin
        bx_d    = item_i.base_x;
        by_d    = item_i.base_y;
        fs_d    = item_i.first_slot;
        phase_d = PH_HDR_FIRST;
        for (int i = 0; i < 5; i++) begin
          hdr_d[i] = 8'd0;
        end
        gtc_d   = 9'd0;
        pi_d    = 10'd0;
        pend_d  = 8'd0;
        abort_d = 1'b0;
      end else if (!abort_q) begin
        if (phase_q < PH_X) begin
          if (phase_q < PH_HDR_CNT) begin
            hdr_d[phase_q[2:0]] = item_i.data_byte;
          end
          phase_d = phase_q + 4'd1;
          if (phase_q == PH_HDR_LAST) begin
            if (st != sfpe_pkg::ST_OK) begin
              push_o.push           = 1'b1;
              push_o.res.last_piece = 1'b1;
              push_o.res.status     = st;
              abort_d               = 1'b1;
            end else begin
              gtc_d = 9'd0;
              pi_d  = 10'd0;
            end
          end
        end else if (phase_q == PH_X) begin
          pend_d  = item_i.data_byte;
          phase_d = PH_Y;
        end else begin
          phase_d                  = PH_X;
          push_o.push              = 1'b1;
          push_o.res.sprite_slot   = fs_q[6:0] + pi_q[6:0];
          push_o.res.pos_x         = bx_q + {8'd0, pend_q} - sfpe_pkg::X_BIAS;
          push_o.res.pos_y         = by_q[7:0] + item_i.data_byte - sfpe_pkg::Y_BIAS;
          push_o.res.tile_idx      = base_tile_i + gtc_cur;
          push_o.res.is_large      = in_large;
          push_o.res.sprite_width  = sfpe_pkg::SIZE_TBL[size_mode_i][{in_large, 1'b0}];
          push_o.res.sprite_height = sfpe_pkg::SIZE_TBL[size_mode_i][{in_large, 1'b1}];
          push_o.res.last_piece    = (pi_inc == total);
          push_o.res.status        = sfpe_pkg::ST_OK;
          gtc_d                    = in_large ? step_l : (gtc_cur + 9'd1);
          pi_d                     = pi_inc;
          abort_d                  = (pi_inc >= total);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR_FIRST;
      for (int i = 0; i < 5; i++) begin
        hdr_q[i] <= 8'd0;
      end
      gtc_q   <= 9'd0;
      pi_q    <= 10'd0;
      pend_q  <= 8'd0;
      bx_q    <= 16'd0;
      by_q    <= 16'd0;
      fs_q    <= 8'd0;
      abort_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      gtc_q   <= gtc_d;
      pi_q    <= pi_d;
      pend_q  <= pend_d;
      bx_q    <= bx_d;
      by_q    <= by_d;
      fs_q    <= fs_d;
      abort_q <= abort_d;
    end
  end

endmodule

/* rtl/sfpe_out_q.sv */
module sfpe_out_q (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfpe_pkg::res_push_t push_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfpe_pkg::out_t      out_req_o
);

  sfpe_pkg::out_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_req_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i.push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i.push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/sprite_frame_piece_expander.sv */
// A request is held in the input register and decoded once the result queue has room; any
// sprite or status result it yields is queued there and offered on the output port.
// Throughput: one request per cycle; a two-entry result queue absorbs output stalls, and
// the input stalls only while that queue is full.
// Reset is asynchronous and active low: input register and result queue empty, registers
// clear to zero but the abort flag sets, so record bytes are ignored until the first start.
module sprite_frame_piece_expander #(
  parameter int MAX_PIECES   = 64,
  parameter int SPRITE_SLOTS = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sfpe_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sfpe_pkg::out_t out_req_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [8:0]     cfg_data_i
);

  logic                in_vld_q;
  sfpe_pkg::in_t       in_q;
  logic                full;
  logic                fire;
  logic                accept;
  logic [2:0]          size_mode_q;
  logic [8:0]          base_tile_q;
  sfpe_pkg::res_push_t push;

  assign in_stall_o = in_vld_q && full;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = in_vld_q && !full;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      size_mode_q <= 3'd0;
      base_tile_q <= 9'd0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfpe_pkg::CFG_SIZE_MODE: size_mode_q <= cfg_data_i[2:0];
          sfpe_pkg::CFG_BASE_TILE: base_tile_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  sfpe_frame #(
    .MAX_PIECES  (MAX_PIECES),
    .SPRITE_SLOTS(SPRITE_SLOTS)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_q),
    .size_mode_i(size_mode_q),
    .base_tile_i(base_tile_q),
    .push_o     (push)
  );

  sfpe_out_q u_out_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

endmodule

/* rtl/sfpe_chk.sv */
`include "sprite_frame_piece_expander_defines.svh"

module sfpe_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sfpe_pkg::out_t out_req_o
);

  // A stalled result stays offered and unchanged.
  `SFPE_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_req_o), "stalled result changed")

  // The input is only held off while results are waiting downstream.
  `SFPE_ASSERT_IMP(a_stall_backed, in_stall_o, out_valid_o, "input stalled with no result pending")

  // A status result closes the frame and carries no sprite.
  `SFPE_ASSERT_IMP(a_status_clean, out_valid_o && (out_req_o.status != sfpe_pkg::ST_OK), out_req_o.last_piece && (out_req_o.sprite_width == 7'd0) && (out_req_o.tile_idx == 9'd0) && (out_req_o.sprite_slot == 7'd0), "status result not cleared")

  // A sprite result always has a size from the table.
  `SFPE_ASSERT_IMP(a_sprite_size, out_valid_o && (out_req_o.status == sfpe_pkg::ST_OK), (out_req_o.sprite_width >= 7'd8) && (out_req_o.sprite_height >= 7'd8), "sprite size missing")

endmodule

bind sprite_frame_piece_expander sfpe_chk u_sfpe_chk (.*);

/* tb/sv/tb_top.sv */
module tb_top;

  logic           clk_i     = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  sfpe_pkg::in_t  in_req    = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  sfpe_pkg::out_t out_req;
  logic           cfg_we    = 1'b0;
  logic           cfg_idx   = sfpe_pkg::CFG_SIZE_MODE;
  logic [8:0]     cfg_data  = '0;

  sprite_frame_piece_expander uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Each row holds small width, small height, large width, large height.
  localparam logic [6:0] OBJ_SIZE [8][4] = '{
    '{7'd8,  7'd8,  7'd16, 7'd16},
    '{7'd8,  7'd8,  7'd32, 7'd32},
    '{7'd8,  7'd8,  7'd64, 7'd64},
    '{7'd16, 7'd16, 7'd32, 7'd32},
    '{7'd16, 7'd16, 7'd64, 7'd64},
    '{7'd32, 7'd32, 7'd64, 7'd64},
    '{7'd16, 7'd32, 7'd32, 7'd64},
    '{7'd16, 7'd32, 7'd32, 7'd32}
  };

  sfpe_pkg::in_t  req_q[$];
  sfpe_pkg::out_t sprite_q[$];

  logic [2:0]  size_sel  = '0;
  logic [8:0]  tile_base = '0;
  logic [3:0]  rec_phase = '0;
  logic [7:0]  hdr [5]   = '{default: '0};
  logic [8:0]  grp_tile  = '0;
  logic [9:0]  piece_n   = '0;
  logic [7:0]  x_byte    = '0;
  logic [15:0] org_x     = '0;
  logic [15:0] org_y     = '0;
  logic [7:0]  slot0     = '0;
  bit          frame_idle = 1'b1;

  bit in_took   = 1'b0;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int in_gap    = 0;
  int out_gap   = 0;
  int hold_cnt  = 0;
  int fails     = 0;
  int n_taken   = 0;
  int n_sprites = 0;
  int n_status  = 0;
  sfpe_pkg::out_t got_exp;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic expand_request(input sfpe_pkg::in_t rq);
    sfpe_pkg::out_t o;
    int             total;
    int             nl;
    int             ns;
    logic [1:0]     st;
    bit             lg;
    o = '0;
    if (rq.kind == sfpe_pkg::KIND_START) begin
      org_x      = rq.base_x;
      org_y      = rq.base_y;
      slot0      = rq.first_slot;
      rec_phase  = '0;
      hdr        = '{default: '0};
      grp_tile   = '0;
      piece_n    = '0;
      x_byte     = '0;
      frame_idle = 1'b0;
      return;
    end
    if (frame_idle) return;
    total = int'(hdr[0]) + int'(hdr[1]) + int'(hdr[3]);
    if (rec_phase < 8) begin
      if (rec_phase < 5) hdr[rec_phase[2:0]] = rq.data_byte;
      rec_phase = rec_phase + 4'd1;
      if (rec_phase == 8) begin
        total = int'(hdr[0]) + int'(hdr[1]) + int'(hdr[3]);
        st = sfpe_pkg::ST_OK;
        if (total > 64) begin
          st = sfpe_pkg::ST_TOO_MANY;
        end else if (slot0 > 128 || total > 128 - int'(slot0)) begin
          st = sfpe_pkg::ST_NO_SLOTS;
        end else if (total == 0) begin
          st = sfpe_pkg::ST_EMPTY;
        end
        if (st != sfpe_pkg::ST_OK) begin
          o.last_piece = 1'b1;
          o.status     = st;
          sprite_q.push_back(o);
          frame_idle = 1'b1;
        end
        grp_tile = '0;
        piece_n  = '0;
      end
    end else if (rec_phase == 8) begin
      x_byte    = rq.data_byte;
      rec_phase = 4'd9;
    end else begin
      rec_phase = 4'd8;
      nl = int'(hdr[0]);
      ns = int'(hdr[1]);
      if (piece_n < nl) begin
        lg = 1'b1;
      end else if (piece_n < nl + ns) begin
        lg = 1'b0;
        if (piece_n == nl) grp_tile = {1'b0, hdr[2]};
      end else begin
        lg = 1'b0;
        if (piece_n == nl + ns) grp_tile = {1'b0, hdr[4]};
      end
      o.sprite_slot   = 7'(slot0 + piece_n);
      o.pos_x         = org_x + {8'h00, x_byte} - 16'h0080;
      o.pos_y         = 8'(org_y + {8'h00, rq.data_byte} - 16'h0070);
      o.tile_idx      = tile_base + grp_tile;
      o.is_large      = lg;
      o.sprite_width  = OBJ_SIZE[size_sel][lg ? 2 : 0];
      o.sprite_height = OBJ_SIZE[size_sel][lg ? 3 : 1];
      o.last_piece    = (int'(piece_n) + 1 == total);
      o.status        = sfpe_pkg::ST_OK;
      sprite_q.push_back(o);
      if (lg) begin
        grp_tile = grp_tile + 9'd2;
        if (grp_tile[4]) grp_tile = grp_tile + 9'h010;
      end else begin
        grp_tile = grp_tile + 9'd1;
      end
      piece_n = piece_n + 10'd1;
      if (int'(piece_n) >= total) frame_idle = 1'b1;
    end
  endtask

  task automatic cmp_field(input string nm, input logic [15:0] e, input logic [15:0] g);
    if (e !== g) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, g);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    in_took = in_valid && !in_stall;
    if (out_valid && !out_stall) begin
      if (sprite_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $time, out_req);
        fails++;
      end else begin
        got_exp = sprite_q.pop_front();
        cmp_field("sprite_slot", 16'(got_exp.sprite_slot), 16'(out_req.sprite_slot));
        cmp_field("pos_x", got_exp.pos_x, out_req.pos_x);
        cmp_field("pos_y", 16'(got_exp.pos_y), 16'(out_req.pos_y));
        cmp_field("tile_idx", 16'(got_exp.tile_idx), 16'(out_req.tile_idx));
        cmp_field("is_large", 16'(got_exp.is_large), 16'(out_req.is_large));
        cmp_field("sprite_width", 16'(got_exp.sprite_width), 16'(out_req.sprite_width));
        cmp_field("sprite_height", 16'(got_exp.sprite_height), 16'(out_req.sprite_height));
        cmp_field("last_piece", 16'(got_exp.last_piece), 16'(out_req.last_piece));
        cmp_field("status", 16'(got_exp.status), 16'(out_req.status));
        if (got_exp.status == sfpe_pkg::ST_OK) n_sprites++;
        else n_status++;
      end
    end
    if (in_took) begin
      expand_request(in_req);
      n_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        in_gap = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        in_req   <= req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt  = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_req(input logic k, input logic [7:0] b, input logic [15:0] bx,
                          input logic [15:0] by, input logic [7:0] sl);
    sfpe_pkg::in_t r;
    r.kind       = k;
    r.data_byte  = b;
    r.base_x     = bx;
    r.base_y     = by;
    r.first_slot = sl;
    req_q.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_req(sfpe_pkg::KIND_BYTE, b, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic queue_frame(input int nl, input int ns, input int na, input int sl,
                             input int np);
    push_req(sfpe_pkg::KIND_START, 8'($urandom), 16'($urandom), 16'($urandom), 8'(sl));
    push_byte(8'(nl));
    push_byte(8'(ns));
    push_byte(8'($urandom));
    push_byte(8'(na));
    push_byte(8'($urandom));
    repeat (3) push_byte(8'($urandom));
    repeat (2 * np) push_byte(8'($urandom));
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_q.size() != 0 || in_valid || sprite_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [2:0] m, input logic [8:0] t);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= sfpe_pkg::CFG_SIZE_MODE;
    cfg_data <= {6'($urandom), m};
    size_sel = m;
    @(negedge clk_i);
    cfg_idx  <= sfpe_pkg::CFG_BASE_TILE;
    cfg_data <= t;
    tile_base = t;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_total(input int lim);
    if (lim <= 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, lim);
    return $urandom_range(1, lim < 8 ? lim : 8);
  endfunction

  initial begin
    int budget;
    int pick;
    int sl;
    int lim;
    int total;
    int nl;
    int ns;
    int np;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    write_cfg(3'd7, 9'd511);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_req(sfpe_pkg::KIND_START, 8'hFF, 16'h8000, 16'h7FFF, 8'd125);
    push_byte(8'd1);
    push_byte(8'd1);
    push_byte(8'hFF);
    push_byte(8'd1);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h55);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h70);
    push_byte(8'hAA);
    push_req(sfpe_pkg::KIND_START, 8'h00, 16'h7FFF, 16'h8000, 8'd128);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    repeat (4) push_byte(8'($urandom));

    for (int p = 1; p <= 8; p++) begin
      wait_drained();
      write_cfg(3'(p - 1), p == 1 ? 9'd0 : p == 2 ? 9'd511 : 9'($urandom));
      if (p == 8) calm = 1'b1;
      budget = 0;
      if (p == 3) begin
        nl = $urandom_range(0, 64);
        ns = $urandom_range(0, 64 - nl);
        queue_frame(nl, ns, 64 - nl - ns, $urandom_range(0, 64), 64);
        hold_req = 1'b1;
      end
      while (budget < 65) begin
        pick = $urandom_range(0, 99);
        sl = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 128) : $urandom_range(0, 100);
        lim = (128 - sl < 64) ? 128 - sl : 64;
        if (pick < 80) begin
          total = pick_total(lim);
          nl = $urandom_range(0, total);
          ns = $urandom_range(0, total - nl);
          np = (pick < 68) ? total : $urandom_range(0, total);
          queue_frame(nl, ns, total - nl - ns, sl, np);
          budget += 9 + 2 * np;
          if (pick < 68 && $urandom_range(0, 3) == 0) push_byte(8'($urandom));
        end else if (pick < 84) begin
          np = $urandom_range(0, 7);
          push_req(sfpe_pkg::KIND_START, 8'($urandom), 16'($urandom), 16'($urandom), 8'(sl));
          repeat (np) push_byte(8'($urandom));
          budget += 1 + np;
        end else if (pick < 91) begin
          queue_frame($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                      sl, $urandom_range(0, 1));
          budget += 9;
        end else if (pick < 96) begin
          sl = $urandom_range(100, 128);
          total = $urandom_range(129 - sl, 64);
          nl = $urandom_range(0, total);
          queue_frame(nl, total - nl, 0, sl, $urandom_range(0, 1));
          budget += 9;
        end else begin
          queue_frame(0, 0, 0, sl, $urandom_range(0, 1));
          budget += 9;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d requests under nine register settings, with a long output hold.",
             n_taken);
    $display("Checked %0d sprites and %0d status results.", n_sprites, n_status);
    if (fails == 0 && sprite_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sfpe_pkg.sv
rtl/sfpe_frame.sv
rtl/sfpe_out_q.sv
rtl/sprite_frame_piece_expander.sv
rtl/sfpe_chk.sv
tb/sv/tb_top.sv
